// ===== hw/rtl/bap_pkg.sv =====
`default_nettype none
package bap_pkg;

  // lattice size limit
  localparam int unsigned MAX_STEPS_DEF = 256;

  // register map, index = paddr / 4
  localparam logic [2:0] REG_STEPS  = 3'd0;
  localparam logic [2:0] REG_GROWTH = 3'd1;
  localparam logic [2:0] REG_SHRINK = 3'd2;
  localparam logic [2:0] REG_RISE   = 3'd3;
  localparam logic [2:0] REG_DISC   = 3'd4;

  // register reset values
  localparam logic [8:0]  STEPS_RST  = 9'd200;
  localparam logic [31:0] GROWTH_RST = 32'd1128793641;
  localparam logic [31:0] SHRINK_RST = 32'd2042748723;
  localparam logic [31:0] RISE_RST   = 32'd2100247598;
  localparam logic [31:0] DISC_RST   = 32'd2147161547;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHR_MUL,
    ST_SHR_UPD,
    ST_LEAF_M0,
    ST_LEAF_M1,
    ST_LEAF_WR,
    ST_LVL_M0,
    ST_LVL_M1,
    ST_RD,
    ST_M1,
    ST_M2,
    ST_WR,
    ST_OUT_RD,
    ST_OUT
  } state_t;

  // round half up after a right shift, then saturate to 32 bits
  function automatic logic [31:0] rnd_sat(input logic [64:0] x, input int unsigned sh);
    logic [65:0] s;
    s = {1'b0, x} + (66'd1 << (sh - 1));
    s = s >> sh;
    return (|s[65:32]) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // exercise value, clamped at zero
  function automatic logic [31:0] intrinsic(input logic [31:0] strike,
                                            input logic [31:0] price);
    return (strike > price) ? (strike - price) : 32'd0;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bap_mem.sv =====
`default_nettype none
module bap_mem #(
  parameter int unsigned DEPTH = 257,
  parameter int unsigned AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr0,
  input  wire logic [AW-1:0] raddr1,
  output logic [31:0]        rdata0,
  output logic [31:0]        rdata1
);

  logic [31:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/binomial_american_put_pricer.sv =====
`default_nettype none
// American put pricer on a binomial lattice.
// Input channel (in_valid/in_ready) carries one word: spot_price and
// exercise_price, both unsigned Q16.16. Output channel (out_valid/out_ready)
// returns option_value, unsigned Q16.16, one word per input word.
// Lattice parameters are loaded through the APB port by the user, only
// while the block is idle; the block does not enforce this. One word is
// priced at a time, each node by a read, multiply, multiply, write-back
// loop on the value memory.
// in_ready is high only while no word is in progress; a new word may be
// taken while the previous result still waits in the output register.
// If the receiver stalls, the finished result waits until out_ready,
// then the block returns to idle. Reset is synchronous: it clears the
// handshake state and loads the register defaults. The value memory is
// not cleared; each word writes every entry before reading it.
module binomial_american_put_pricer #(
  parameter int unsigned MAX_STEPS = bap_pkg::MAX_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] spot_price,
  input  wire logic [31:0] exercise_price,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      option_value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned DEPTH = MAX_STEPS + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  // configuration registers
  logic [8:0]  steps_in_use;
  logic [31:0] growth_per_step;
  logic [31:0] shrink_per_step;
  logic [31:0] rise_probability;
  logic [31:0] discount_per_step;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_in_use      <= bap_pkg::STEPS_RST;
      growth_per_step   <= bap_pkg::GROWTH_RST;
      shrink_per_step   <= bap_pkg::SHRINK_RST;
      rise_probability  <= bap_pkg::RISE_RST;
      discount_per_step <= bap_pkg::DISC_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        bap_pkg::REG_STEPS:  steps_in_use      <= pwdata[8:0];
        bap_pkg::REG_GROWTH: growth_per_step   <= pwdata;
        bap_pkg::REG_SHRINK: shrink_per_step   <= pwdata;
        bap_pkg::REG_RISE:   rise_probability  <= pwdata;
        bap_pkg::REG_DISC:   discount_per_step <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      bap_pkg::REG_STEPS:  prdata = {23'd0, steps_in_use};
      bap_pkg::REG_GROWTH: prdata = growth_per_step;
      bap_pkg::REG_SHRINK: prdata = shrink_per_step;
      bap_pkg::REG_RISE:   prdata = rise_probability;
      bap_pkg::REG_DISC:   prdata = discount_per_step;
      default:             prdata = 32'd0;
    endcase
  end

  // sequencer and datapath registers
  bap_pkg::state_t state, state_next;
  logic [AW-1:0] n_steps;
  logic [AW-1:0] cnt;
  logic [AW-1:0] j;
  logic [AW-1:0] lvl;
  logic [31:0]   strike;
  logic [31:0]   level_base_price;
  logic [31:0]   node_price;
  logic [31:0]   next_price;
  logic [64:0]   prod_pr;
  logic [64:0]   prod_a;
  logic [64:0]   prod_b;
  logic [64:0]   prod_h;

  // memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr0;
  logic [AW-1:0] mem_raddr1;
  logic [31:0]   mem_rdata0;
  logic [31:0]   mem_rdata1;

  bap_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr0(mem_raddr0),
    .raddr1(mem_raddr1),
    .rdata0(mem_rdata0),
    .rdata1(mem_rdata1)
  );

  // arithmetic helpers
  logic [32:0] fall_probability;
  logic [65:0] wsum;
  logic [31:0] cont;
  logic [31:0] held;
  logic [31:0] ex_val;
  logic [31:0] pr_rnd;
  logic        out_free;
  logic        last_node;

  assign fall_probability = 33'h1_0000_0000 - {1'b0, rise_probability};
  assign wsum      = {1'b0, prod_a} + {1'b0, prod_b} + 66'h8000_0000;
  assign cont      = (|wsum[65:64]) ? 32'hFFFF_FFFF : wsum[63:32];
  assign held      = bap_pkg::rnd_sat(prod_h, 31);
  assign ex_val    = bap_pkg::intrinsic(strike, node_price);
  assign pr_rnd    = bap_pkg::rnd_sat(prod_pr, 30);
  assign out_free  = !out_valid || out_ready;
  assign last_node = ((j + AW'(1)) == lvl);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bap_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = j;
    mem_wdata  = ex_val;
    mem_raddr0 = '0;
    mem_raddr1 = '0;
    case (state)
      bap_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = bap_pkg::ST_SHR_MUL;
        end
      end
      bap_pkg::ST_SHR_MUL: begin
        state_next = (cnt == n_steps) ? bap_pkg::ST_LEAF_M0 : bap_pkg::ST_SHR_UPD;
      end
      bap_pkg::ST_SHR_UPD: state_next = bap_pkg::ST_SHR_MUL;
      bap_pkg::ST_LEAF_M0: state_next = bap_pkg::ST_LEAF_M1;
      bap_pkg::ST_LEAF_M1: state_next = bap_pkg::ST_LEAF_WR;
      bap_pkg::ST_LEAF_WR: begin
        mem_we = 1'b1;
        if (j == n_steps) begin
          state_next = (n_steps == '0) ? bap_pkg::ST_OUT_RD : bap_pkg::ST_LVL_M0;
        end else begin
          state_next = bap_pkg::ST_LEAF_M0;
        end
      end
      bap_pkg::ST_LVL_M0: state_next = bap_pkg::ST_LVL_M1;
      bap_pkg::ST_LVL_M1: state_next = bap_pkg::ST_RD;
      bap_pkg::ST_RD: begin
        mem_raddr0 = j;
        mem_raddr1 = j + AW'(1);
        state_next = bap_pkg::ST_M1;
      end
      bap_pkg::ST_M1: state_next = bap_pkg::ST_M2;
      bap_pkg::ST_M2: state_next = bap_pkg::ST_WR;
      bap_pkg::ST_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (held > ex_val) ? held : ex_val;
        if (last_node) begin
          state_next = (lvl == AW'(1)) ? bap_pkg::ST_OUT_RD : bap_pkg::ST_LVL_M0;
        end else begin
          state_next = bap_pkg::ST_RD;
        end
      end
      bap_pkg::ST_OUT_RD: state_next = bap_pkg::ST_OUT;
      bap_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = bap_pkg::ST_IDLE;
        end
      end
      default: state_next = bap_pkg::ST_IDLE;
    endcase
  end

  // lattice datapath
  always_ff @(posedge clk) begin
    case (state)
      bap_pkg::ST_IDLE: begin
        if (in_valid) begin
          strike           <= exercise_price;
          level_base_price <= spot_price;
          cnt              <= '0;
          n_steps <= (32'(steps_in_use) > MAX_STEPS) ? AW'(MAX_STEPS) : AW'(steps_in_use);
        end
      end
      bap_pkg::ST_SHR_MUL: begin
        prod_pr <= {33'd0, level_base_price} * {33'd0, shrink_per_step};
        if (cnt == n_steps) begin
          node_price <= level_base_price;
          j          <= '0;
        end
      end
      bap_pkg::ST_SHR_UPD: begin
        level_base_price <= bap_pkg::rnd_sat(prod_pr, 31);
        cnt              <= cnt + AW'(1);
      end
      bap_pkg::ST_LEAF_M0: prod_pr <= {33'd0, node_price} * {33'd0, growth_per_step};
      bap_pkg::ST_LEAF_M1: prod_pr <= {33'd0, pr_rnd} * {33'd0, growth_per_step};
      bap_pkg::ST_LEAF_WR: begin
        node_price <= pr_rnd;
        lvl        <= n_steps;
        if (j != n_steps) begin
          j <= j + AW'(1);
        end
      end
      bap_pkg::ST_LVL_M0: prod_pr <= {33'd0, level_base_price} * {33'd0, growth_per_step};
      bap_pkg::ST_LVL_M1: begin
        level_base_price <= pr_rnd;
        node_price       <= pr_rnd;
        j                <= '0;
      end
      bap_pkg::ST_RD: prod_pr <= {33'd0, node_price} * {33'd0, growth_per_step};
      bap_pkg::ST_M1: begin
        prod_a  <= {33'd0, rise_probability} * {33'd0, mem_rdata1};
        prod_b  <= {32'd0, fall_probability} * {33'd0, mem_rdata0};
        prod_pr <= {33'd0, pr_rnd} * {33'd0, growth_per_step};
      end
      bap_pkg::ST_M2: begin
        prod_h     <= {33'd0, cont} * {33'd0, discount_per_step};
        next_price <= pr_rnd;
      end
      bap_pkg::ST_WR: begin
        node_price <= next_price;
        if (last_node) begin
          lvl <= lvl - AW'(1);
        end else begin
          j <= j + AW'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bap_pkg::ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bap_pkg::ST_OUT && out_free) begin
      option_value <= mem_rdata0;
    end
  end

endmodule
`default_nettype wire
